// ----- rtl/wstq_pkg.sv -----
package wstq_pkg;

	// request kinds
	localparam logic [1:0] KIND_PUSH  = 2'd0;
	localparam logic [1:0] KIND_POP   = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_UNDER = 2'd3;

	// pop sources
	localparam logic [1:0] SRC_OWN    = 2'd0;
	localparam logic [1:0] SRC_SHARED = 2'd1;
	localparam logic [1:0] SRC_STOLEN = 2'd2;

	localparam int unsigned HANDLE_W = 16;
	localparam int unsigned GRP_W    = 3;
	localparam int unsigned ENTRY_W  = HANDLE_W + GRP_W;
	localparam logic [7:0]  COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic [GRP_W-1:0]    grp;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

endpackage

// ----- rtl/work_stealing_task_queues.sv -----
// Sequence: push, completion and failed pop pass through the execute and output states;
// a successful pop passes through execute, a registered slot read, then output.
// A new request is taken only once the sequencer is back in idle after the output state,
// and a result not yet taken holds the next request in execute.
// Reset (arst_n, asynchronous) empties every queue and clears all group counts;
// slot RAMs are not cleared.
module work_stealing_task_queues
	import wstq_pkg::*;
#(
	parameter int unsigned WORKERS      = 4,
	parameter int unsigned DEQUE_DEPTH  = 16,
	parameter int unsigned SHARED_DEPTH = 32,
	parameter int unsigned GROUPS       = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [2:0]          requester,
	input  logic [HANDLE_W-1:0] task_handle,
	input  logic [GRP_W-1:0]    group_index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [HANDLE_W-1:0] got_task,
	output logic [GRP_W-1:0]    got_group,
	output logic [1:0]          source,
	output logic [1:0]          victim,
	output logic [7:0]          group_pending,
	output logic                group_done
);

	localparam int unsigned WI_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int unsigned DI_W = $clog2(DEQUE_DEPTH);
	localparam int unsigned DF_W = $clog2(DEQUE_DEPTH + 1);
	localparam int unsigned DS_W = DF_W + 1;
	localparam int unsigned SI_W = $clog2(SHARED_DEPTH);
	localparam int unsigned SF_W = $clog2(SHARED_DEPTH + 1);
	localparam int unsigned SS_W = SF_W + 1;
	localparam int unsigned WA_W = $clog2(WORKERS * DEQUE_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_OUT} state_t;

	state_t              state_q;
	logic [1:0]          kind_q;
	logic [2:0]          req_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [GRP_W-1:0]    grp_q;
	logic [DI_W-1:0]     head_q [WORKERS];
	logic [DF_W-1:0]     fill_q [WORKERS];
	logic [SI_W-1:0]     shead_q;
	logic [SF_W-1:0]     sfill_q;
	logic                from_shared_q;

	// result register
	logic                ovalid_q;
	logic [1:0]          status_q, source_q, victim_q;
	logic [HANDLE_W-1:0] task_q;
	logic [GRP_W-1:0]    ggrp_q;
	logic [7:0]          pend_q;
	logic                done_q;

	logic            is_worker;
	logic [WI_W-1:0] rw;
	logic            own_ok, steal_ok;
	logic [WI_W-1:0] steal_w;
	logic            go;

	assign is_worker = ({29'd0, req_q} < WORKERS);
	assign rw        = WI_W'(req_q);
	assign own_ok    = is_worker && fill_q[rw] != '0;
	// execute step advances once the previous result is gone or leaving
	assign go        = state_q == S_EXEC && (!ovalid_q || out_ready);

	// steal victim: lowest other non-empty worker
	always_comb begin
		steal_ok = 1'b0;
		steal_w  = '0;
		for (int w = WORKERS - 1; w >= 0; w--) begin
			if (fill_q[w] != '0 && !(is_worker && rw == WI_W'(w))) begin
				steal_ok = 1'b1;
				steal_w  = WI_W'(w);
			end
		end
	end

	// slot addresses and write enables, ring indexes wrap by compare and subtract
	logic            wwe, swe;
	logic [WA_W-1:0] wwaddr, wraddr;
	logic [SI_W-1:0] swaddr, sraddr;
	entry_t          wentry, wrd, srd;
	logic [DI_W-1:0] own_back, own_tail, steal_head_nx;
	logic [DS_W-1:0] own_sum, own_sum_m1;
	logic [SI_W-1:0] s_tail, shead_nx;
	logic [SS_W-1:0] s_sum;

	assign wentry     = '{grp: grp_q, handle: handle_q};
	assign own_sum    = DS_W'(head_q[rw]) + DS_W'(fill_q[rw]);
	assign own_sum_m1 = own_sum - 1'b1;
	assign own_tail   = (own_sum >= DS_W'(DEQUE_DEPTH)) ?
		DI_W'(own_sum - DS_W'(DEQUE_DEPTH)) : DI_W'(own_sum);
	assign own_back   = (own_sum_m1 >= DS_W'(DEQUE_DEPTH)) ?
		DI_W'(own_sum_m1 - DS_W'(DEQUE_DEPTH)) : DI_W'(own_sum_m1);
	assign steal_head_nx = (head_q[steal_w] == DI_W'(DEQUE_DEPTH - 1)) ?
		'0 : head_q[steal_w] + 1'b1;
	assign s_sum      = SS_W'(shead_q) + SS_W'(sfill_q);
	assign s_tail     = (s_sum >= SS_W'(SHARED_DEPTH)) ?
		SI_W'(s_sum - SS_W'(SHARED_DEPTH)) : SI_W'(s_sum);
	assign shead_nx   = (shead_q == SI_W'(SHARED_DEPTH - 1)) ? '0 : shead_q + 1'b1;
	assign wwe = go && kind_q == KIND_PUSH && is_worker
		&& fill_q[rw] != DF_W'(DEQUE_DEPTH);
	assign swe = go && kind_q == KIND_PUSH && !is_worker
		&& sfill_q != SF_W'(SHARED_DEPTH);
	assign wwaddr = WA_W'(rw * DEQUE_DEPTH + own_tail);
	assign wraddr = own_ok ? WA_W'(rw * DEQUE_DEPTH + own_back)
		: WA_W'(steal_w * DEQUE_DEPTH + head_q[steal_w]);
	assign swaddr = s_tail;
	assign sraddr = shead_q;

	wstq_ram #(.WIDTH(ENTRY_W), .DEPTH(WORKERS * DEQUE_DEPTH)) u_wram (
		.clk(clk), .we(wwe), .waddr(wwaddr), .wdata(wentry),
		.raddr(wraddr), .rdata(wrd)
	);
	wstq_ram #(.WIDTH(ENTRY_W), .DEPTH(SHARED_DEPTH)) u_sram (
		.clk(clk), .we(swe), .waddr(swaddr), .wdata(wentry),
		.raddr(sraddr), .rdata(srd)
	);

	// group counts, shared by push/completion and the pop readback
	logic            c_inc, c_dec;
	logic [GRP_W-1:0] c_grp;
	logic [7:0]      c_cnt;
	logic            grp_ok;
	entry_t          popped;

	assign popped = from_shared_q ? srd : wrd;
	assign c_grp  = (state_q == S_READ) ? popped.grp : grp_q;
	assign grp_ok = ({29'd0, c_grp} < GROUPS);
	assign c_inc  = wwe || swe;
	assign c_dec  = go && kind_q == KIND_DONE;

	wstq_counts #(.GROUPS(GROUPS)) u_counts (
		.clk(clk), .arst_n(arst_n), .grp(c_grp), .inc(c_inc), .dec(c_dec),
		.count(c_cnt)
	);

	logic [7:0] cnt_inc;
	assign cnt_inc = (c_cnt == COUNT_MAX || !grp_ok) ? c_cnt : c_cnt + 8'd1;

	assign in_ready = state_q == S_IDLE;

	// execute step result
	logic [1:0] ex_status, ex_source, ex_victim;
	logic [7:0] ex_pend;
	logic       ex_done;
	state_t     ex_next;

	always_comb begin
		ex_status = ST_OK;
		ex_source = SRC_OWN;
		ex_victim = '0;
		ex_pend   = '0;
		ex_done   = 1'b0;
		ex_next   = S_OUT;
		case (kind_q)
			KIND_PUSH: begin
				ex_status = (wwe || swe) ? ST_OK : ST_FULL;
				ex_pend   = (wwe || swe) ? cnt_inc : c_cnt;
			end
			KIND_POP: begin
				if (own_ok) begin
					ex_source = SRC_OWN;
					ex_next   = S_READ;
				end else if (sfill_q != '0) begin
					ex_source = SRC_SHARED;
					ex_next   = S_READ;
				end else if (steal_ok) begin
					ex_source = SRC_STOLEN;
					ex_victim = 2'(steal_w);
					ex_next   = S_READ;
				end else begin
					ex_status = ST_EMPTY;
				end
			end
			KIND_DONE: begin
				if (c_cnt == 8'd0) begin
					ex_status = ST_UNDER;
				end else begin
					ex_pend = c_cnt - 8'd1;
					ex_done = (c_cnt == 8'd1);
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ovalid_q      <= 1'b0;
			shead_q       <= '0;
			sfill_q       <= '0;
			from_shared_q <= 1'b0;
			for (int w = 0; w < WORKERS; w++) begin
				head_q[w] <= '0;
				fill_q[w] <= '0;
			end
		end else begin
			if (state_q == S_OUT) ovalid_q <= 1'b1;
			else if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q   <= kind;
						req_q    <= requester;
						handle_q <= task_handle;
						grp_q    <= group_index;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go) begin
						status_q <= ex_status;
						task_q   <= '0;
						ggrp_q   <= '0;
						source_q <= ex_source;
						victim_q <= ex_victim;
						pend_q   <= ex_pend;
						done_q   <= ex_done;
						state_q  <= ex_next;
						case (kind_q)
							KIND_PUSH: begin
								if (wwe) fill_q[rw] <= fill_q[rw] + 1'b1;
								if (swe) sfill_q <= sfill_q + 1'b1;
							end
							KIND_POP: begin
								if (own_ok) begin
									fill_q[rw]    <= fill_q[rw] - 1'b1;
									from_shared_q <= 1'b0;
								end else if (sfill_q != '0) begin
									shead_q       <= shead_nx;
									sfill_q       <= sfill_q - 1'b1;
									from_shared_q <= 1'b1;
								end else if (steal_ok) begin
									head_q[steal_w] <= steal_head_nx;
									fill_q[steal_w] <= fill_q[steal_w] - 1'b1;
									from_shared_q   <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					task_q  <= popped.handle;
					ggrp_q  <= popped.grp;
					pend_q  <= c_cnt;
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = ovalid_q;
	assign status        = status_q;
	assign got_task      = task_q;
	assign got_group     = ggrp_q;
	assign source        = source_q;
	assign victim        = victim_q;
	assign group_pending = pend_q;
	assign group_done    = done_q;

endmodule

// ----- rtl/wstq_ram.sv -----
module wstq_ram #(
	parameter int unsigned WIDTH = 19,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/wstq_counts.sv -----
module wstq_counts
	import wstq_pkg::*;
#(
	parameter int unsigned GROUPS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [GRP_W-1:0] grp,
	input  logic             inc,
	input  logic             dec,
	output logic [7:0]       count
);

	localparam int unsigned GI_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

	logic [7:0]      cnt_q [GROUPS];
	logic [GI_W-1:0] gi;
	logic            in_range;

	assign in_range = ({29'd0, grp} < GROUPS);
	assign gi       = GI_W'(grp);
	assign count    = in_range ? cnt_q[gi] : 8'd0;

	// saturating up, floored down, increment wins; out-of-range groups are ignored here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GROUPS; i++) cnt_q[i] <= '0;
		end else if (in_range) begin
			if (inc && cnt_q[gi] != COUNT_MAX) cnt_q[gi] <= cnt_q[gi] + 8'd1;
			else if (dec && cnt_q[gi] != 8'd0) cnt_q[gi] <= cnt_q[gi] - 8'd1;
		end
	end

endmodule

// ----- rtl/wstq_checker.sv -----
module wstq_checker
	import wstq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [1:0] source,
	input logic [7:0] group_pending,
	input logic       group_done
);

	// a request is never answered in the very next cycle
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !(out_valid && !$past(out_valid)))
		else $error("result too early");

	// done only with zero count and ok status
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && group_done) |-> (group_pending == 8'd0 && status == ST_OK))
		else $error("bad done");

	// a failed pop reports no source
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> source == SRC_OWN)
		else $error("source on empty pop");

	// held result stays valid with its pending count unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(group_pending)))
		else $error("result dropped");

endmodule

bind work_stealing_task_queues wstq_checker u_wstq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.source(source), .group_pending(group_pending), .group_done(group_done)
);

// ----- dv/work_stealing_task_queues_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, predicts the scheduler's answer for every accepted
// request and compares each result against the oldest prediction.
module work_stealing_task_queues_checker
	import wstq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [2:0]          requester,
	input  logic [HANDLE_W-1:0] task_handle,
	input  logic [GRP_W-1:0]    group_index,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [1:0]          status,
	input  logic [HANDLE_W-1:0] got_task,
	input  logic [GRP_W-1:0]    got_group,
	input  logic [1:0]          source,
	input  logic [1:0]          victim,
	input  logic [7:0]          group_pending,
	input  logic                group_done,
	output int                  errors,
	output int                  outstanding
);

	localparam int NWORK  = 4;
	localparam int DDEPTH = 16;
	localparam int SDEPTH = 32;
	localparam int NGRP   = 8;
	localparam int PDEPTH = 64;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] got_task;
		logic [GRP_W-1:0]    got_group;
		logic [1:0]          source;
		logic [1:0]          victim;
		logic [7:0]          pending;
		logic                done;
	} answer_t;

	// shadow of the queues and group counts
	entry_t     deque_mem [NWORK][DDEPTH];
	int         deque_head [NWORK];
	int         deque_fill [NWORK];
	entry_t     fifo_mem [SDEPTH];
	int         fifo_head;
	int         fifo_fill;
	logic [7:0] group_count [NGRP];

	// predictions in flight, as a ring
	answer_t    expected_answers [PDEPTH];
	int         pred_wr;
	int         pred_rd;

	assign outstanding = pred_wr - pred_rd;

	function automatic answer_t schedule(input logic [1:0] k, input logic [2:0] req,
			input logic [HANDLE_W-1:0] h, input logic [GRP_W-1:0] g);
		answer_t a;
		bit      is_worker;
		bit      taken;
		entry_t  e;
		int      pos;
		a = '0;
		is_worker = req < NWORK;
		taken = 0;
		e = '0;
		case (k)
			KIND_PUSH: begin
				e.grp = g;
				e.handle = h;
				if (is_worker) begin
					if (deque_fill[req] < DDEPTH) begin
						pos = (deque_head[req] + deque_fill[req]) % DDEPTH;
						deque_mem[req][pos] = e;
						deque_fill[req]++;
						taken = 1;
					end
				end else if (fifo_fill < SDEPTH) begin
					fifo_mem[(fifo_head + fifo_fill) % SDEPTH] = e;
					fifo_fill++;
					taken = 1;
				end
				if (!taken) a.status = ST_FULL;
				if (taken && group_count[g] != COUNT_MAX) group_count[g]++;
				a.pending = group_count[g];
			end
			KIND_POP: begin
				if (is_worker && deque_fill[req] != 0) begin
					pos = (deque_head[req] + deque_fill[req] - 1) % DDEPTH;
					e = deque_mem[req][pos];
					deque_fill[req]--;
					a.source = SRC_OWN;
					taken = 1;
				end
				if (!taken && fifo_fill != 0) begin
					e = fifo_mem[fifo_head];
					fifo_head = (fifo_head + 1) % SDEPTH;
					fifo_fill--;
					a.source = SRC_SHARED;
					taken = 1;
				end
				for (int w = 0; w < NWORK && !taken; w++) begin
					if (!(is_worker && w == req) && deque_fill[w] != 0) begin
						e = deque_mem[w][deque_head[w]];
						deque_head[w] = (deque_head[w] + 1) % DDEPTH;
						deque_fill[w]--;
						a.source = SRC_STOLEN;
						a.victim = w[1:0];
						taken = 1;
					end
				end
				if (taken) begin
					a.got_task = e.handle;
					a.got_group = e.grp;
					a.pending = group_count[e.grp];
				end else begin
					a.status = ST_EMPTY;
				end
			end
			KIND_DONE: begin
				if (group_count[g] == 0) begin
					a.status = ST_UNDER;
				end else begin
					group_count[g]--;
					a.pending = group_count[g];
					a.done = group_count[g] == 0;
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	// predict on accepted requests, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		answer_t seen;
		if (!arst_n) begin
			errors <= 0;
			pred_wr = 0;
			pred_rd = 0;
			fifo_head = 0;
			fifo_fill = 0;
			for (int w = 0; w < NWORK; w++) begin
				deque_head[w] = 0;
				deque_fill[w] = 0;
			end
			for (int i = 0; i < NGRP; i++) group_count[i] = '0;
		end else begin
			if (out_valid && out_ready) begin
				seen = '{status, got_task, got_group, source, victim, group_pending,
					group_done};
				if (pred_wr == pred_rd) begin
					$display("%0t: unexpected result %p", $time, seen);
					errors <= errors + 1;
				end else begin
					want = expected_answers[pred_rd % PDEPTH];
					pred_rd++;
					if (seen !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, seen);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_answers[pred_wr % PDEPTH] = schedule(kind, requester,
					task_handle, group_index);
				pred_wr++;
			end
		end
	end

endmodule

// ----- dv/work_stealing_task_queues_test.sv -----
`timescale 1ns / 1ps

module work_stealing_task_queues_test;
	import wstq_pkg::*;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_ready;
	logic [1:0]          kind = '0;
	logic [2:0]          requester = '0;
	logic [HANDLE_W-1:0] task_handle = '0;
	logic [GRP_W-1:0]    group_index = '0;
	logic                out_valid;
	logic                out_ready = 0;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] got_task;
	logic [GRP_W-1:0]    got_group;
	logic [1:0]          source;
	logic [1:0]          victim;
	logic [7:0]          group_pending;
	logic                group_done;
	int                  errors;
	int                  outstanding;
	bit                  calm = 0;
	bit                  hold_sink = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	work_stealing_task_queues dut (.*);
	work_stealing_task_queues_checker checker_i (.*);

	// offer one request and wait for its acceptance, idling first at random
	task automatic send(input logic [1:0] k, input logic [2:0] r,
			input logic [15:0] h, input logic [2:0] g);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		requester <= r;
		task_handle <= h;
		group_index <= g;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_sender();
		in_valid <= 0;
		@(posedge clk);
	endtask

	// random request: mostly push/pop/complete with a bias to well-formed use
	task automatic random_request();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			send(KIND_PUSH, 3'($urandom_range(0, 7)), 16'($urandom),
				3'($urandom_range(0, 7)));
		else if (sel < 80)
			send(KIND_POP, 3'($urandom_range(0, 7)), 16'($urandom),
				3'($urandom_range(0, 7)));
		else if (sel < 98)
			send(KIND_DONE, 3'($urandom_range(0, 7)), 16'($urandom),
				3'($urandom_range(0, 7)));
		else
			send(KIND_SPARE, 3'($urandom_range(0, 7)), 16'($urandom),
				3'($urandom_range(0, 7)));
	endtask

	// receiver: random stalls, a long hold-off on request
	always @(posedge clk) begin
		if (hold_sink || (!calm && $urandom_range(0, 5) == 0)) begin
			out_ready <= 0;
			repeat (hold_sink ? 1 : $urandom_range(1, 11)) @(posedge clk);
		end
		out_ready <= !hold_sink;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empties, extremes, fill to full, underflow
		send(KIND_POP, 3'd0, 16'h0000, 3'd0);
		send(KIND_POP, 3'd7, 16'hFFFF, 3'd7);
		send(KIND_DONE, 3'd4, 16'h0000, 3'd0);
		send(KIND_SPARE, 3'd7, 16'hFFFF, 3'd7);
		send(KIND_PUSH, 3'd0, 16'hFFFF, 3'd7);
		send(KIND_PUSH, 3'd0, 16'h0000, 3'd0);
		send(KIND_PUSH, 3'd4, 16'hA5A5, 3'd5);
		send(KIND_PUSH, 3'd3, 16'h5A5A, 3'd2);
		send(KIND_POP, 3'd0, 16'h0, 3'd0);
		send(KIND_POP, 3'd1, 16'h0, 3'd0);
		send(KIND_POP, 3'd1, 16'h0, 3'd0);
		send(KIND_POP, 3'd5, 16'h0, 3'd0);
		send(KIND_DONE, 3'd0, 16'h0, 3'd7);
		send(KIND_DONE, 3'd0, 16'h0, 3'd7);
		for (int i = 0; i < 17; i++) send(KIND_PUSH, 3'd2, 16'(i), 3'd1);
		for (int i = 0; i < 33; i++) send(KIND_PUSH, 3'd6, 16'(i), 3'd1);
		for (int i = 0; i < 260; i++) send(KIND_PUSH, 3'(1 + (i & 1)), 16'(i), 3'd3);
		for (int i = 0; i < 60; i++) send(KIND_POP, 3'(i % 6), 16'h0, 3'd0);
		for (int i = 0; i < 20; i++) send(KIND_DONE, 3'(i % 5), 16'h0, 3'(i % 8));

		// long receiver hold-off while requests keep coming
		hold_sink = 1;
		fork
			repeat (200) @(posedge clk);
			for (int i = 0; i < 30; i++) random_request();
		join_any
		hold_sink = 0;
		wait fork;

		// sender waits until everything has drained
		idle_sender();
		while (outstanding != 0) @(posedge clk);

		for (int i = 0; i < 600; i++) random_request();
		calm = 1;
		for (int i = 0; i < 200; i++) random_request();
		idle_sender();

		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/wstq_pkg.sv
rtl/wstq_ram.sv
rtl/wstq_counts.sv
rtl/work_stealing_task_queues.sv
rtl/wstq_checker.sv
dv/work_stealing_task_queues_checker.sv
dv/work_stealing_task_queues_test.sv
